// File: rtl/core/cst_pkg.sv
// ---------------------------------------------------------------------------
// cst_pkg: shared codes and byte tables of the C subset tokenizer
// Token kinds, scanner mode codes, operator and keyword tables and byte class
// helpers used by the scanner, and the queue geometry of the queue and back part.
// ---------------------------------------------------------------------------
package cst_pkg;

	localparam logic [5:0] KD_EOF     = 6'd0;
	localparam logic [5:0] KD_IDENT   = 6'd1;
	localparam logic [5:0] KD_KEYWORD = 6'd2;
	localparam logic [5:0] KD_INT     = 6'd14;
	localparam logic [5:0] KD_FLOAT   = 6'd15;
	localparam logic [5:0] KD_CHAR    = 6'd16;
	localparam logic [5:0] KD_STRING  = 6'd17;
	localparam logic [5:0] KD_PAIR    = 6'd18;
	localparam logic [5:0] KD_SINGLE  = 6'd32;
	localparam logic [5:0] KD_DIAG    = 6'd53;

	localparam int MODE_W = 4;
	localparam logic [MODE_W-1:0] M_IDLE      = 4'd0;
	localparam logic [MODE_W-1:0] M_IDENT     = 4'd1;
	localparam logic [MODE_W-1:0] M_INT       = 4'd2;
	localparam logic [MODE_W-1:0] M_DOT       = 4'd3;
	localparam logic [MODE_W-1:0] M_FRAC      = 4'd4;
	localparam logic [MODE_W-1:0] M_EXP0      = 4'd5;
	localparam logic [MODE_W-1:0] M_EXP       = 4'd6;
	localparam logic [MODE_W-1:0] M_CH_OPEN   = 4'd7;
	localparam logic [MODE_W-1:0] M_CH_ESC    = 4'd8;
	localparam logic [MODE_W-1:0] M_CH_CLOSE  = 4'd9;
	localparam logic [MODE_W-1:0] M_STR       = 4'd10;
	localparam logic [MODE_W-1:0] M_STR_ESC   = 4'd11;
	localparam logic [MODE_W-1:0] M_OP        = 4'd12;
	localparam logic [MODE_W-1:0] M_LINE      = 4'd13;
	localparam logic [MODE_W-1:0] M_BLK       = 4'd14;
	localparam logic [MODE_W-1:0] M_BLK_STAR  = 4'd15;

	localparam int KW_CHARS = 8;
	localparam int KW_W     = 8 * KW_CHARS;
	localparam int KW_NUM   = 12;

	// Words per queue entry and queue geometry.
	localparam int MAX_TOK = 3;
	localparam int NTOK_W  = 2;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	localparam logic [7:0] SINGLE_OPS [21] = '{"+", "-", "*", "/", "%", "=", "<", ">",
		"!", "&", "|", "^", "~", "(", ")", "{", "}", "[", "]", ",", ";"};
	localparam logic [15:0] PAIR_OPS [14] = '{"++", "--", "+=", "-=", "*=", "/=", "==",
		"!=", "<=", ">=", "<<", ">>", "&&", "||"};
	localparam logic [KW_W-1:0] KEYWORDS [KW_NUM] = '{"int", "float", "char", "void",
		"if", "else", "while", "for", "do", "return", "break", "continue"};

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	// Kind of a one-byte operator, or the diagnostic kind when none matches.
	function automatic logic [5:0] single_code(input logic [7:0] b);
		logic [5:0] k;
		k = KD_DIAG;
		for (int i = 20; i >= 0; i--) begin
			if (SINGLE_OPS[i] == b) k = KD_SINGLE + 6'(i);
		end
		return k;
	endfunction

	function automatic logic pair_first(input logic [7:0] b);
		logic f;
		f = 1'b0;
		for (int i = 0; i < 14; i++) begin
			if (PAIR_OPS[i][15:8] == b) f = 1'b1;
		end
		return f;
	endfunction

	function automatic logic pair_hit(input logic [7:0] a, input logic [7:0] b);
		logic f;
		f = 1'b0;
		for (int i = 0; i < 14; i++) begin
			if (PAIR_OPS[i] == {a, b}) f = 1'b1;
		end
		return f;
	endfunction

	function automatic logic [5:0] pair_code(input logic [7:0] a, input logic [7:0] b);
		logic [5:0] k;
		k = KD_PAIR;
		for (int i = 13; i >= 0; i--) begin
			if (PAIR_OPS[i] == {a, b}) k = KD_PAIR + 6'(i);
		end
		return k;
	endfunction

	function automatic logic [5:0] ident_code(input logic [KW_W-1:0] w, input logic short_ok);
		logic [5:0] k;
		k = KD_IDENT;
		for (int i = KW_NUM - 1; i >= 0; i--) begin
			if (short_ok && KEYWORDS[i] == w) k = KD_KEYWORD + 6'(i);
		end
		return k;
	endfunction

endpackage

// File: rtl/core/cst_front.sv
// ---------------------------------------------------------------------------
// cst_front: byte scanner of the C subset tokenizer
// Takes one source byte or end mark per cycle while the queue is not full,
// advances the scanner state and writes the up to three tokens that the byte closes into the queue.
// ---------------------------------------------------------------------------
module cst_front import cst_pkg::*; #(
	parameter int OW = 32,
	parameter int LW = 16,
	parameter int RW = 6 + OW + LW + 10,
	parameter int EW = NTOK_W + MAX_TOK * RW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    source_byte,
	input  logic          end_mark,
	input  logic          q_full,
	output logic          push,
	output logic [EW-1:0] push_data
);

	typedef struct packed {
		logic [5:0]    kind;
		logic [OW-1:0] start;
		logic [LW-1:0] len;
		logic [7:0]    val;
		logic          bad;
		logic          unt;
	} tok_t;

	logic [MODE_W-1:0] mode_q, mode_n;
	logic [7:0]        pend_q, pend_n;
	logic [OW-1:0]     tstart_q, tstart_n;
	logic [LW-1:0]     cnt_q, cnt_n;
	logic [KW_W-1:0]   kw_q, kw_n;
	logic [7:0]        lval_q, lval_n;
	logic              lflag_q, lflag_n;
	logic [OW-1:0]     boff_q, boff_n;

	tok_t        em [MAX_TOK];
	logic [1:0]  n;
	logic [7:0]  b;
	logic [LW-1:0] cnt1, cnt2;
	tok_t        id_tok;
	logic        do_start;

	logic [MODE_W-1:0] sb_mode;
	logic sb_open, sb_id, sb_lit, sb_op, sb_emit;
	tok_t sb_tok;
	logic [5:0] sc;

	function automatic tok_t mk(input logic [5:0] k, input logic [OW-1:0] s,
			input logic [LW-1:0] l, input logic [7:0] v, input logic bd, input logic u);
		tok_t t;
		t.kind = k; t.start = s; t.len = l; t.val = v; t.bad = bd; t.unt = u;
		return t;
	endfunction

	function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] c, input logic [1:0] k);
		logic [LW:0] s;
		s = {1'b0, c} + (LW+1)'(k);
		return s[LW] ? {LW{1'b1}} : s[LW-1:0];
	endfunction

	assign in_ready = !q_full;
	assign b = source_byte;

	// Decode of a byte scanned between tokens.
	always_comb begin
		sb_mode = M_IDLE; sb_open = 1'b0; sb_id = 1'b0; sb_lit = 1'b0;
		sb_op = 1'b0; sb_emit = 1'b0;
		sc = single_code(b);
		sb_tok = mk(sc, boff_q, LW'(1), (sc == KD_DIAG) ? b : 8'd0, 1'b0, 1'b0);
		if (is_blank(b)) begin
			sb_mode = M_IDLE;
		end else if (is_alpha(b)) begin
			sb_mode = M_IDENT; sb_open = 1'b1; sb_id = 1'b1;
		end else if (is_digit(b)) begin
			sb_mode = M_INT; sb_open = 1'b1;
		end else if (b == "'") begin
			sb_mode = M_CH_OPEN; sb_open = 1'b1; sb_lit = 1'b1;
		end else if (b == "\"") begin
			sb_mode = M_STR; sb_open = 1'b1; sb_lit = 1'b1;
		end else if (pair_first(b)) begin
			sb_mode = M_OP; sb_open = 1'b1; sb_op = 1'b1;
		end else begin
			sb_emit = 1'b1;
		end
	end

	always_comb begin
		mode_n = mode_q; pend_n = pend_q; tstart_n = tstart_q; cnt_n = cnt_q;
		kw_n = kw_q; lval_n = lval_q; lflag_n = lflag_q; boff_n = boff_q;
		for (int i = 0; i < MAX_TOK; i++) em[i] = '0;
		n = 2'd0;
		do_start = 1'b0;
		cnt1 = sat_add(cnt_q, 2'd1);
		cnt2 = sat_add(cnt_q, 2'd2);
		id_tok = mk(ident_code(kw_q, cnt_q <= LW'(KW_CHARS)), tstart_q, cnt_q,
			8'd0, 1'b0, 1'b0);
		if (end_mark) begin
			unique case (mode_q)
				M_IDENT: begin em[n] = id_tok; n = n + 2'd1; end
				M_INT: begin
					em[n] = mk(KD_INT, tstart_q, cnt_q, 8'd0, 1'b0, 1'b0); n = n + 2'd1;
				end
				M_DOT: begin
					em[n] = mk(KD_INT, tstart_q, cnt_q, 8'd0, 1'b0, 1'b0); n = n + 2'd1;
					em[n] = mk(KD_DIAG, boff_q - OW'(1), LW'(1), ".", 1'b0, 1'b0);
					n = n + 2'd1;
				end
				M_FRAC, M_EXP0, M_EXP: begin
					em[n] = mk(KD_FLOAT, tstart_q, cnt_q, 8'd0, 1'b0, 1'b0); n = n + 2'd1;
				end
				M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
					em[n] = mk(KD_CHAR, tstart_q, cnt_q, lval_q, lflag_q, 1'b1);
					n = n + 2'd1;
				end
				M_STR, M_STR_ESC: begin
					em[n] = mk(KD_STRING, tstart_q, cnt_q, 8'd0, lflag_q, 1'b1);
					n = n + 2'd1;
				end
				M_OP: begin
					em[n] = mk(single_code(pend_q), tstart_q, LW'(1), 8'd0, 1'b0, 1'b0);
					n = n + 2'd1;
				end
				M_BLK, M_BLK_STAR: begin
					em[n] = mk(KD_DIAG, tstart_q, cnt_q, 8'd0, 1'b0, 1'b1); n = n + 2'd1;
				end
				default: begin
				end
			endcase
			em[n] = mk(KD_EOF, boff_q, '0, 8'd0, 1'b0, 1'b0);
			n = n + 2'd1;
			mode_n = M_IDLE;
			boff_n = '0;
		end else begin
			boff_n = boff_q + OW'(1);
			unique case (mode_q)
				M_IDENT: begin
					if (is_alpha(b) || is_digit(b)) begin
						kw_n = {kw_q[KW_W-9:0], b}; cnt_n = cnt1;
					end else begin
						em[n] = id_tok; n = n + 2'd1; do_start = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(b)) cnt_n = cnt1;
					else if (b == ".") mode_n = M_DOT;
					else if (b == "e" || b == "E") begin
						cnt_n = cnt1; mode_n = M_EXP0;
					end else begin
						em[n] = mk(KD_INT, tstart_q, cnt_q, 8'd0, 1'b0, 1'b0);
						n = n + 2'd1; do_start = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(b)) begin
						cnt_n = cnt2; mode_n = M_FRAC;
					end else begin
						em[n] = mk(KD_INT, tstart_q, cnt_q, 8'd0, 1'b0, 1'b0); n = n + 2'd1;
						em[n] = mk(KD_DIAG, boff_q - OW'(1), LW'(1), ".", 1'b0, 1'b0);
						n = n + 2'd1; do_start = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_digit(b)) cnt_n = cnt1;
					else if (b == "e" || b == "E") begin
						cnt_n = cnt1; mode_n = M_EXP0;
					end else begin
						em[n] = mk(KD_FLOAT, tstart_q, cnt_q, 8'd0, 1'b0, 1'b0);
						n = n + 2'd1; do_start = 1'b1;
					end
				end
				M_EXP0, M_EXP: begin
					if (is_digit(b) || (mode_q == M_EXP0 && (b == "+" || b == "-"))) begin
						cnt_n = cnt1; mode_n = M_EXP;
					end else begin
						em[n] = mk(KD_FLOAT, tstart_q, cnt_q, 8'd0, 1'b0, 1'b0);
						n = n + 2'd1; do_start = 1'b1;
					end
				end
				M_CH_OPEN: begin
					cnt_n = cnt1;
					if (b == "\\") mode_n = M_CH_ESC;
					else if (b == "'") begin
						em[n] = mk(KD_CHAR, tstart_q, cnt1, lval_q, lflag_q, 1'b0);
						n = n + 2'd1; mode_n = M_IDLE;
					end else begin
						lval_n = b; mode_n = M_CH_CLOSE;
					end
				end
				M_CH_ESC: begin
					cnt_n = cnt1;
					mode_n = M_CH_CLOSE;
					if (b == "n") lval_n = 8'd10;
					else if (b == "t") lval_n = 8'd9;
					else if (b == "r") lval_n = 8'd13;
					else if (b == "0") lval_n = 8'd0;
					else if (b == "\\" || b == "'") lval_n = b;
					else begin
						lval_n = b; lflag_n = 1'b1;
					end
				end
				M_CH_CLOSE: begin
					if (b == "'") begin
						cnt_n = cnt1;
						em[n] = mk(KD_CHAR, tstart_q, cnt1, lval_q, lflag_q, 1'b0);
						n = n + 2'd1; mode_n = M_IDLE;
					end else begin
						em[n] = mk(KD_CHAR, tstart_q, cnt_q, lval_q, lflag_q, 1'b1);
						n = n + 2'd1; do_start = 1'b1;
					end
				end
				M_STR: begin
					cnt_n = cnt1;
					if (b == "\"") begin
						em[n] = mk(KD_STRING, tstart_q, cnt1, 8'd0, lflag_q, 1'b0);
						n = n + 2'd1; mode_n = M_IDLE;
					end else if (b == "\\") mode_n = M_STR_ESC;
				end
				M_STR_ESC: begin
					cnt_n = cnt1;
					mode_n = M_STR;
					if (!(b == "n" || b == "t" || b == "r" || b == "0" || b == "\\"
						|| b == "\"")) lflag_n = 1'b1;
				end
				M_OP: begin
					if (pend_q == "/" && b == "/") mode_n = M_LINE;
					else if (pend_q == "/" && b == "*") begin
						cnt_n = cnt1; mode_n = M_BLK;
					end else if (pair_hit(pend_q, b)) begin
						em[n] = mk(pair_code(pend_q, b), tstart_q, LW'(2), 8'd0, 1'b0, 1'b0);
						n = n + 2'd1; mode_n = M_IDLE;
					end else begin
						em[n] = mk(single_code(pend_q), tstart_q, LW'(1), 8'd0, 1'b0, 1'b0);
						n = n + 2'd1; do_start = 1'b1;
					end
				end
				M_LINE: begin
					if (b == 8'h0A) mode_n = M_IDLE;
				end
				M_BLK, M_BLK_STAR: begin
					cnt_n = cnt1;
					if (mode_q == M_BLK_STAR && b == "/") mode_n = M_IDLE;
					else mode_n = (b == "*") ? M_BLK_STAR : M_BLK;
				end
				default: do_start = 1'b1;
			endcase
			if (do_start) begin
				mode_n = sb_mode;
				if (sb_open) begin
					tstart_n = boff_q; cnt_n = LW'(1);
				end
				if (sb_id) kw_n = KW_W'(b);
				if (sb_lit) begin
					lval_n = 8'd0; lflag_n = 1'b0;
				end
				if (sb_op) pend_n = b;
				if (sb_emit) begin
					em[n] = sb_tok; n = n + 2'd1;
				end
			end
		end
	end

	assign push      = in_valid && in_ready && (n != 2'd0);
	assign push_data = {n, em[2], em[1], em[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; tstart_q <= '0; cnt_q <= '0;
			kw_q <= '0; lval_q <= '0; lflag_q <= 1'b0; boff_q <= '0;
		end else if (in_valid && in_ready) begin
			mode_q <= mode_n; pend_q <= pend_n; tstart_q <= tstart_n; cnt_q <= cnt_n;
			kw_q <= kw_n; lval_q <= lval_n; lflag_q <= lflag_n; boff_q <= boff_n;
		end
	end

endmodule

// File: rtl/core/cst_queue.sv
// ---------------------------------------------------------------------------
// cst_queue: token group queue of the C subset tokenizer
// Short register queue that holds the token groups of scanned bytes between
// the scanner and the word sequencer.
// ---------------------------------------------------------------------------
module cst_queue import cst_pkg::*; #(
	parameter int EW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [EW-1:0] push_data,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output logic [EW-1:0] head
);

	logic [EW-1:0]     mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("queue fill count lost a write");

endmodule

// File: rtl/core/cst_back.sv
// ---------------------------------------------------------------------------
// cst_back: word sequencer of the C subset tokenizer
// Presents the tokens of the queue head one word at a time and releases the
// group after its last word is taken.
// ---------------------------------------------------------------------------
module cst_back import cst_pkg::*; #(
	parameter int OW = 32,
	parameter int LW = 16,
	parameter int RW = 6 + OW + LW + 10,
	parameter int EW = NTOK_W + MAX_TOK * RW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  logic [EW-1:0] head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [5:0]    token_kind,
	output logic [OW-1:0] start_offset,
	output logic [LW-1:0] token_length,
	output logic [7:0]    char_value,
	output logic          bad_escape,
	output logic          unterminated,
	output logic          last_result
);

	typedef struct packed {
		logic [5:0]    kind;
		logic [OW-1:0] start;
		logic [LW-1:0] len;
		logic [7:0]    val;
		logic          bad;
		logic          unt;
	} tok_t;

	logic [NTOK_W-1:0] idx_q, ntok;
	tok_t              tok;
	logic              last;

	assign ntok = head[EW-1 -: NTOK_W];
	assign tok  = head[idx_q*RW +: RW];
	assign last = (idx_q == ntok - NTOK_W'(1));

	assign out_valid    = !empty;
	assign pop          = out_valid && out_ready && last;
	assign token_kind   = tok.kind;
	assign start_offset = tok.start;
	assign token_length = tok.len;
	assign char_value   = tok.val;
	assign bad_escape   = tok.bad;
	assign unterminated = tok.unt;
	assign last_result  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= last ? '0 : idx_q + NTOK_W'(1);
		end
	end

endmodule

// File: rtl/core/c_subset_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// c_subset_tokenizer_unit: C subset tokenizer, one source byte per cycle
// A byte's tokens are registered in the queue before they reach the output.
// Throughput: one byte per cycle while the queue is not full; words leave one
// at a time on out_ready, so the two or three tokens of one byte leave in turn.
// Reset: arst_n clears the scanner mode, the byte offset and the queue.
// ---------------------------------------------------------------------------
module c_subset_tokenizer_unit import cst_pkg::*; #(
	parameter int OFFSET_WIDTH = 32,
	parameter int LENGTH_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              source_byte,
	input  logic                    end_mark,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [5:0]              token_kind,
	output logic [OFFSET_WIDTH-1:0] start_offset,
	output logic [LENGTH_WIDTH-1:0] token_length,
	output logic [7:0]              char_value,
	output logic                    bad_escape,
	output logic                    unterminated,
	output logic                    last_result
);

	// One token word: kind, offset, length, value and two flags.
	localparam int RW = 6 + OFFSET_WIDTH + LENGTH_WIDTH + 10;
	// One queue entry holds all tokens that a single input word produces.
	localparam int EW = NTOK_W + MAX_TOK * RW;

	logic          push, pop, q_full, q_empty;
	logic [EW-1:0] push_data, head;

	// The scanner handles each byte combinationally and drops a group of
	// up to three tokens into the queue; it stalls only when the queue fills.
	cst_front #(.OW(OFFSET_WIDTH), .LW(LENGTH_WIDTH), .RW(RW), .EW(EW)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .source_byte, .end_mark,
		.q_full, .push, .push_data
	);

	// The queue parts the two sides, so input words keep flowing while a
	// finished token still waits at the output.
	cst_queue #(.EW(EW)) u_queue (
		.clk, .arst_n, .push, .push_data, .pop,
		.full(q_full), .empty(q_empty), .head
	);

	// The sequencer hands out the tokens of the head group in order and
	// flags the last one of the group.
	cst_back #(.OW(OFFSET_WIDTH), .LW(LENGTH_WIDTH), .RW(RW), .EW(EW)) u_back (
		.clk, .arst_n, .empty(q_empty), .head, .pop,
		.out_valid, .out_ready, .token_kind, .start_offset, .token_length,
		.char_value, .bad_escape, .unterminated, .last_result
	);

endmodule
